// File: rtl/sbs_pkg.sv
// Shared constants, request mode codes and controller/datapath interface structs.
package sbs_pkg;

   localparam int MAX_MARKS   = 64;
   localparam int OFFSET_BITS = 48;
   localparam int COUNT_W     = $clog2(MAX_MARKS + 1);
   localparam int RSP_COUNT_W = 7;

   typedef enum logic [1:0] {
      MODE_TOGGLE = 2'd0,
      MODE_CHECK  = 2'd1,
      MODE_JUMP   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic capture;
      logic compare;
      logic select;
      logic update;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

// File: rtl/sbs_ctrl.sv
// Request sequencer: steps each request through capture, compare, select, update and response load.
module sbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbs_pkg::stat_type stat,
   output sbs_pkg::cmd_type  cmd
);
   import sbs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_SEL  = 5'b00100,
      S_UPD  = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_SEL;
         end
         S_SEL: begin
            cmd.select = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // only one step command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.compare, cmd.select, cmd.update}))
      else $error("more than one step command");

   // a load only happens in the update step or while waiting for the output register
   a_load_order: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_UPD || state_ff == S_RESP))
      else $error("response loaded out of sequence");

   // a captured request always reaches the compare step next
   a_capture_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.compare)
      else $error("compare did not follow capture");

endmodule

// File: rtl/sbs_dpath.sv
// Sorted mark row with per-slot comparators, shift update and response register.
module sbs_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  sbs_pkg::cmd_type                  cmd,
   output sbs_pkg::stat_type                 stat,
   input  logic [1:0]                        req_mode,
   input  logic [sbs_pkg::OFFSET_BITS-1:0]   req_offset,
   input  logic [sbs_pkg::OFFSET_BITS-1:0]   req_doc_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_marked,
   output logic                              rsp_target_found,
   output logic                              rsp_wrapped,
   output logic [sbs_pkg::OFFSET_BITS-1:0]   rsp_target,
   output logic [sbs_pkg::RSP_COUNT_W-1:0]   rsp_mark_count,
   output logic                              rsp_status
);
   import sbs_pkg::*;

   // request registers
   mode_type               mode_ff;
   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] lim_ff;

   // mark row and fill level
   logic [OFFSET_BITS-1:0] marks_ff [MAX_MARKS];
   logic [OFFSET_BITS-1:0] marks_in [MAX_MARKS];
   logic [COUNT_W-1:0]     count_ff;

   // compare flags
   logic [MAX_MARKS-1:0] lt_ff, eq_ff, gt_ff;
   logic [MAX_MARKS-1:0] lt_in, eq_in, gt_in;

   // select results
   logic [MAX_MARKS:0]     t_ext;
   logic [COUNT_W-1:0]     pc;
   logic [MAX_MARKS-1:0]   eq_p, gt_p, gt_low, pc_oh;
   logic                   found, has_gt, has_eq, full;
   logic [OFFSET_BITS-1:0] tgt;

   logic                   wr_del_ff, wr_ins_ff;
   logic [MAX_MARKS-1:0]   del_oh_ff, ins_oh_ff;
   logic [COUNT_W-1:0]     new_count_ff, new_count_in;
   logic                   res_marked_ff, res_found_ff, res_wrapped_ff, res_status_ff;
   logic [OFFSET_BITS-1:0] res_target_ff;

   // update masks
   logic [MAX_MARKS-1:0] dn_mask, up_mask;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_marked_ff, rsp_found_ff, rsp_wrapped_ff, rsp_status_ff;
   logic [OFFSET_BITS-1:0] rsp_target_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   // compare: every slot against offset and limit, masked by fill level
   always_comb begin
      for (int i = 0; i < MAX_MARKS; i++) begin
         lt_in[i] = (COUNT_W'(i) < count_ff) && (marks_ff[i] < lim_ff);
         eq_in[i] = (COUNT_W'(i) < count_ff) && (marks_ff[i] == pos_ff);
         gt_in[i] = (COUNT_W'(i) < count_ff) && (marks_ff[i] > pos_ff);
      end
   end

   // select: lt flags form a prefix, its length is the pruned count
   always_comb begin
      t_ext = {1'b0, lt_ff};
      pc    = '0;
      for (int i = 0; i < MAX_MARKS; i++) begin
         if (t_ext[i] && !t_ext[i+1]) pc = pc | COUNT_W'(i + 1);
      end
      eq_p   = eq_ff & lt_ff;
      gt_p   = gt_ff & lt_ff;
      gt_low = gt_p & (~gt_p + 1'b1);
      found  = |lt_ff;
      has_gt = |gt_p;
      has_eq = |eq_p;
      full   = (pc == COUNT_W'(MAX_MARKS));
      tgt    = '0;
      for (int i = 0; i < MAX_MARKS; i++) begin
         pc_oh[i] = (COUNT_W'(i) == pc);
         tgt      = tgt | (marks_ff[i] & {OFFSET_BITS{gt_low[i]}});
      end
      unique case (mode_ff)
         MODE_TOGGLE: new_count_in = has_eq ? pc - 1'b1 : (full ? pc : pc + 1'b1);
         MODE_CHECK:  new_count_in = count_ff;
         MODE_JUMP:   new_count_in = pc;
         MODE_CLEAR:  new_count_in = '0;
         default:     new_count_in = count_ff;
      endcase
   end

   // update: delete shifts down from the hit, insert shifts up above the slot
   always_comb begin
      dn_mask  = ~(del_oh_ff - 1'b1);
      up_mask  = ~(ins_oh_ff - 1'b1) & ~ins_oh_ff;
      marks_in = marks_ff;
      if (wr_del_ff) begin
         for (int j = 0; j < MAX_MARKS - 1; j++) begin
            if (dn_mask[j]) marks_in[j] = marks_ff[j+1];
         end
      end
      if (wr_ins_ff) begin
         for (int j = 1; j < MAX_MARKS; j++) begin
            if (up_mask[j]) marks_in[j] = marks_ff[j-1];
         end
         for (int j = 0; j < MAX_MARKS; j++) begin
            if (ins_oh_ff[j]) marks_in[j] = pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         pos_ff  <= req_offset;
         lim_ff  <= req_doc_length;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
         gt_ff <= gt_in;
      end
      if (cmd.select) begin
         wr_del_ff      <= (mode_ff == MODE_TOGGLE) && has_eq;
         wr_ins_ff      <= (mode_ff == MODE_TOGGLE) && !has_eq && !full;
         del_oh_ff      <= eq_p;
         ins_oh_ff      <= has_gt ? gt_low : pc_oh;
         new_count_ff   <= new_count_in;
         res_marked_ff  <= (mode_ff == MODE_CHECK) && (|eq_ff);
         res_found_ff   <= (mode_ff == MODE_JUMP) && found;
         res_wrapped_ff <= (mode_ff == MODE_JUMP) && found && !has_gt;
         res_target_ff  <= ((mode_ff == MODE_JUMP) && found) ?
                           (has_gt ? tgt : marks_ff[0]) : '0;
         res_status_ff  <= ((mode_ff == MODE_TOGGLE) && !has_eq && full) ?
                           STATUS_FULL : STATUS_OK;
      end
      if (cmd.update) begin
         marks_ff <= marks_in;
      end
      if (cmd.load) begin
         rsp_marked_ff  <= res_marked_ff;
         rsp_found_ff   <= res_found_ff;
         rsp_wrapped_ff <= res_wrapped_ff;
         rsp_target_ff  <= res_target_ff;
         rsp_count_ff   <= new_count_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) count_ff <= new_count_ff;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_marked    = rsp_marked_ff;
   assign rsp_target_found = rsp_found_ff;
   assign rsp_wrapped      = rsp_wrapped_ff;
   assign rsp_target       = rsp_target_ff;
   assign rsp_mark_count   = RSP_COUNT_W'(rsp_count_ff);
   assign rsp_status       = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_MARKS))
      else $error("fill level beyond row depth");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_W'(2)) |-> (marks_ff[0] < marks_ff[1]))
      else $error("mark row not ascending");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |->
      (rsp_count_ff == COUNT_W'(MAX_MARKS)))
      else $error("dropped insert without a full row");

   a_wrap_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wrapped_ff) |-> rsp_found_ff)
      else $error("wrap flagged without a target");

endmodule

// File: rtl/sorted_bookmark_set.sv
// Top level of the sorted bookmark set: sequencer plus mark row datapath.
//
// Usage
//   Request channel (req_*): mode, offset and doc_length; taken at a rising
//   edge with req_valid high and req_stall low. req_stall is high while a
//   request is being worked on, so one request is in flight at a time.
//   Response channel (rsp_*): exactly one response per request, taken at a
//   rising edge with rsp_valid high and rsp_stall low.
//   Order: a taken request is compared, selected and updated in turn, and
//   its response is then loaded into the output register that drives rsp_valid.
//   Requests do not overlap: a new one is taken only once the last one's
//   response is loaded; compare, select and update work over the row of 64
//   mark slots (all slots compared in parallel, then a single shift).
//   Stall: a waiting response sits in the output register; the next request
//   is still taken and worked on, and only its load waits until the
//   register is free, holding req_stall high meanwhile.
//   Reset (synchronous, active high): the set is empty, no response pending.
//   Mark slots themselves are not cleared; only slots below the fill level
//   are ever looked at.
module sorted_bookmark_set (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [sbs_pkg::OFFSET_BITS-1:0]   req_offset,
   input  logic [sbs_pkg::OFFSET_BITS-1:0]   req_doc_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_marked,
   output logic                              rsp_target_found,
   output logic                              rsp_wrapped,
   output logic [sbs_pkg::OFFSET_BITS-1:0]   rsp_target,
   output logic [sbs_pkg::RSP_COUNT_W-1:0]   rsp_mark_count,
   output logic                              rsp_status
);
   import sbs_pkg::*;

   // step commands down, output register status up
   cmd_type  cmd;
   stat_type stat;

   sbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbs_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_offset       (req_offset),
      .req_doc_length   (req_doc_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_marked    (rsp_is_marked),
      .rsp_target_found (rsp_target_found),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_target       (rsp_target),
      .rsp_mark_count   (rsp_mark_count),
      .rsp_status       (rsp_status)
   );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the sorted bookmark set, with its reply tracker class.
`timescale 1ns / 100ps

import sbs_pkg::*;

typedef struct {
   bit                   is_marked;
   bit                   target_found;
   bit                   wrapped;
   bit [OFFSET_BITS-1:0] target;
   bit [RSP_COUNT_W-1:0] mark_count;
   bit                   status;
} mark_reply_type;

// Mirrors the bookmark set and holds the replies owed for accepted requests.
class bookmark_tracker;
   bit [OFFSET_BITS-1:0] marks [MAX_MARKS];
   int unsigned          fill;
   mark_reply_type       replies_owed [$];
   int unsigned          mismatches;

   function int unsigned size();
      return fill;
   endfunction

   function int unsigned owed();
      return replies_owed.size();
   endfunction

   function bit [OFFSET_BITS-1:0] entry(int unsigned idx);
      return marks[idx];
   endfunction

   function bit holds(bit [OFFSET_BITS-1:0] pos);
      for (int unsigned i = 0; i < fill; i++)
         if (marks[i] == pos) return 1'b1;
      return 1'b0;
   endfunction

   // drop every mark at or beyond the document length
   function void trim_to(bit [OFFSET_BITS-1:0] limit);
      while (fill > 0 && marks[fill-1] >= limit) fill--;
   endfunction

   function bit toggle_mark(bit [OFFSET_BITS-1:0] pos, bit [OFFSET_BITS-1:0] limit);
      trim_to(limit);
      for (int unsigned i = 0; i < fill; i++) begin
         if (marks[i] == pos) begin
            for (int unsigned j = i; j + 1 < fill; j++) marks[j] = marks[j+1];
            fill--;
            trim_to(limit);
            return STATUS_OK;
         end
         if (marks[i] > pos) begin
            if (fill >= MAX_MARKS) return STATUS_FULL;
            for (int unsigned j = fill; j > i; j--) marks[j] = marks[j-1];
            marks[i] = pos;
            fill++;
            trim_to(limit);
            return STATUS_OK;
         end
      end
      // larger than everything held: appended, no second trim
      if (fill >= MAX_MARKS) return STATUS_FULL;
      marks[fill] = pos;
      fill++;
      return STATUS_OK;
   endfunction

   function void take_request(mode_type mode, bit [OFFSET_BITS-1:0] pos,
                              bit [OFFSET_BITS-1:0] limit);
      mark_reply_type r;
      r = '{default: 0};
      case (mode)
         MODE_TOGGLE: r.status = toggle_mark(pos, limit);
         MODE_CHECK:  r.is_marked = holds(pos);
         MODE_JUMP: begin
            trim_to(limit);
            if (fill > 0) begin
               r.target_found = 1'b1;
               r.wrapped      = 1'b1;
               r.target       = marks[0];
               for (int unsigned i = 0; i < fill; i++) begin
                  if (marks[i] > pos) begin
                     r.target  = marks[i];
                     r.wrapped = 1'b0;
                     break;
                  end
               end
            end
         end
         default: fill = 0;
      endcase
      r.mark_count = RSP_COUNT_W'(fill);
      replies_owed.push_back(r);
   endfunction

   function void compare(string field, bit [63:0] want, bit [63:0] got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
      end
   endfunction

   function void check_reply(mark_reply_type got);
      mark_reply_type want;
      if (replies_owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: reply arrived with no request outstanding", $realtime);
         return;
      end
      want = replies_owed.pop_front();
      compare("is_marked",    64'(want.is_marked),    64'(got.is_marked));
      compare("target_found", 64'(want.target_found), 64'(got.target_found));
      compare("wrapped",      64'(want.wrapped),      64'(got.wrapped));
      compare("target",       64'(want.target),       64'(got.target));
      compare("mark_count",   64'(want.mark_count),   64'(got.mark_count));
      compare("status",       64'(want.status),       64'(got.status));
   endfunction
endclass

module testbench;

   localparam int                   POOL_SIZE    = 160;
   localparam int                   RANDOM_ITEMS = 800;
   localparam int                   TAIL_CYCLES  = 12;
   localparam bit [OFFSET_BITS-1:0] LEN_MAX      = '1;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_mode;
   logic [OFFSET_BITS-1:0] req_offset;
   logic [OFFSET_BITS-1:0] req_doc_length;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_is_marked;
   logic                   rsp_target_found;
   logic                   rsp_wrapped;
   logic [OFFSET_BITS-1:0] rsp_target;
   logic [RSP_COUNT_W-1:0] rsp_mark_count;
   logic                   rsp_status;

   bookmark_tracker        tracker = new();
   bit [OFFSET_BITS-1:0]   pool [POOL_SIZE];
   int unsigned            requests_sent;
   // when set, neither side idles: back-to-back requests and no reply stalls
   bit                     quiet_spell;
   mark_reply_type         seen;

   sorted_bookmark_set u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_offset       (req_offset),
      .req_doc_length   (req_doc_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_marked    (rsp_is_marked),
      .rsp_target_found (rsp_target_found),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_target       (rsp_target),
      .rsp_mark_count   (rsp_mark_count),
      .rsp_status       (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_spell || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [OFFSET_BITS-1:0] any_offset();
      return OFFSET_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic bit [OFFSET_BITS-1:0] pool_pick();
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // A pool value not currently held, so a toggle of it is an insert.
   function automatic bit [OFFSET_BITS-1:0] unheld_pick();
      bit [OFFSET_BITS-1:0] v;
      do v = pool_pick(); while (tracker.holds(v));
      return v;
   endfunction

   // A held mark where one exists; gives check and jump something to hit.
   function automatic bit [OFFSET_BITS-1:0] held_pick();
      if (tracker.size() == 0) return pool_pick();
      return tracker.entry($urandom_range(0, tracker.size() - 1));
   endfunction

   // Document length: usually everything survives, sometimes a real trim.
   function automatic bit [OFFSET_BITS-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return LEN_MAX;
      if (r < 93) return pool_pick();
      if (r < 97) return any_offset();
      return '0;
   endfunction

   // Offer one request at the falling edge and hold it until taken; the
   // tracker notes it at the rising edge where valid meets a low stall.
   task automatic send_request(mode_type mode, bit [OFFSET_BITS-1:0] pos,
                               bit [OFFSET_BITS-1:0] len);
      int unsigned gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_offset     <= pos;
      req_doc_length <= len;
      do @(posedge clock); while (req_stall);
      tracker.take_request(mode, pos, len);
      requests_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Sender holds off until every owed reply has come back.
   task automatic wait_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.owed() != 0) @(posedge clock);
   endtask

   // Fill the store to capacity, then push a few more inserts that must be
   // refused with the full status, then look around the full set.
   task automatic fill_burst();
      while (tracker.size() < MAX_MARKS) send_request(MODE_TOGGLE, unheld_pick(), LEN_MAX);
      repeat ($urandom_range(2, 4)) send_request(MODE_TOGGLE, unheld_pick(), LEN_MAX);
      repeat ($urandom_range(2, 5)) begin
         send_request(MODE_CHECK, held_pick(), pick_length());
         send_request(MODE_JUMP, held_pick(), LEN_MAX);
      end
   endtask

   // Raw noise: every field random over its whole range.
   task automatic noise_burst();
      repeat ($urandom_range(5, 15))
         send_request(mode_type'($urandom_range(0, 3)), any_offset(), any_offset());
   endtask

   // Mixed traffic mostly over the shared pool, so toggles both add and
   // remove marks and checks and jumps land on held ones.
   task automatic mixed_burst();
      int unsigned          r;
      bit [OFFSET_BITS-1:0] pos;
      repeat ($urandom_range(20, 40)) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            r = $urandom_range(0, 99);
            if (r < 85)      pos = pool_pick();
            else if (r < 95) pos = any_offset();
            else             pos = $urandom_range(0, 1) ? LEN_MAX : '0;
            send_request(MODE_TOGGLE, pos, pick_length());
         end else if (r < 65) begin
            pos = $urandom_range(0, 1) ? held_pick() : pool_pick();
            send_request(MODE_CHECK, pos, any_offset());
         end else if (r < 92) begin
            r = $urandom_range(0, 99);
            if (r < 40)      pos = held_pick();
            else if (r < 80) pos = pool_pick();
            else             pos = any_offset();
            send_request(MODE_JUMP, pos, pick_length());
         end else if (r < 94) begin
            send_request(MODE_CLEAR, any_offset(), any_offset());
         end else begin
            send_request(mode_type'($urandom_range(0, 3)), any_offset(), any_offset());
         end
      end
   endtask

   // Reply side: stalls of random length, none during a quiet spell.
   initial begin
      int unsigned run;
      rsp_stall = 1'b0;
      forever begin
         run = pick_gap();
         repeat (run + 1) @(negedge clock);
         run = pick_gap();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Replies are taken at the rising edge where valid meets a low stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.is_marked    = rsp_is_marked;
         seen.target_found = rsp_target_found;
         seen.wrapped      = rsp_wrapped;
         seen.target       = rsp_target;
         seen.mark_count   = rsp_mark_count;
         seen.status       = rsp_status;
         tracker.check_reply(seen);
      end
   end

   initial begin
      int unsigned base;
      int unsigned kind;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_TOGGLE;
      req_offset     = '0;
      req_doc_length = '0;
      quiet_spell    = 1'b0;
      requests_sent  = 0;
      // half the pool near zero, half spread over the full offset range
      for (int i = 0; i < POOL_SIZE; i++)
         pool[i] = (i % 2 == 0) ? OFFSET_BITS'($urandom_range(0, 1000)) : any_offset();
      pool[0] = '0;
      pool[1] = LEN_MAX;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty set, append beyond the length, ordered inserts,
      // removal, wrap-round, trims down to nothing, clear, bit patterns.
      send_request(MODE_JUMP,   '0, LEN_MAX);          // jump on empty set
      send_request(MODE_CHECK,  '0, LEN_MAX);
      send_request(MODE_TOGGLE, LEN_MAX, '0);          // only entry, no trim
      send_request(MODE_CHECK,  LEN_MAX, '0);          // held despite length
      send_request(MODE_TOGGLE, 48'd5, '0);            // trims, then appends
      send_request(MODE_TOGGLE, 48'd100, LEN_MAX);
      send_request(MODE_TOGGLE, 48'd50, LEN_MAX);      // middle insert
      send_request(MODE_TOGGLE, 48'd75, LEN_MAX);
      send_request(MODE_CHECK,  48'd50, '0);
      send_request(MODE_CHECK,  48'd51, LEN_MAX);
      send_request(MODE_JUMP,   48'd50, LEN_MAX);
      send_request(MODE_JUMP,   48'd100, LEN_MAX);     // wraps to smallest
      send_request(MODE_JUMP,   LEN_MAX, LEN_MAX);
      send_request(MODE_TOGGLE, 48'd50, LEN_MAX);      // removal
      send_request(MODE_JUMP,   '0, 48'd60);           // trims the upper marks
      send_request(MODE_JUMP,   '0, '0);               // trims everything
      send_request(MODE_TOGGLE, 48'hAAAA_AAAA_AAAA, LEN_MAX);
      send_request(MODE_TOGGLE, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      send_request(MODE_CHECK,  48'h5555_5555_5555, 48'h5555_5555_5555);
      send_request(MODE_JUMP,   48'h5555_5555_5555, 48'h5555_5555_5556);
      send_request(MODE_TOGGLE, '0, LEN_MAX);
      send_request(MODE_CLEAR,  LEN_MAX, LEN_MAX);
      send_request(MODE_CHECK,  '0, LEN_MAX);
      send_request(MODE_JUMP,   '0, LEN_MAX);
      wait_replies();

      // Random part, opening with a fill to capacity.
      base = requests_sent;
      fill_burst();
      while (requests_sent - base < RANDOM_ITEMS) begin
         quiet_spell = ($urandom_range(0, 99) < 15);
         kind = $urandom_range(0, 99);
         if (kind < 15)      fill_burst();
         else if (kind < 25) noise_burst();
         else                mixed_burst();
         if ($urandom_range(0, 99) < 10) wait_replies();
      end
      quiet_spell = 1'b0;

      wait_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
